FILE: rtl/ascon_keystream_xor_assert.svh
// assertion macros shared by the keystream xor design
// no dependencies; included by files that carry assertions
`ifndef ASCON_KEYSTREAM_XOR_ASSERT_SVH
`define ASCON_KEYSTREAM_XOR_ASSERT_SVH

// same-cycle implication under async active-low reset
`define AKX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under async active-low reset
`define AKX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ascon_ks_pkg.sv
// types, constants and helper functions for the ascon keystream xor block
// no dependencies
package ascon_ks_pkg;

    typedef logic [63:0] word_t;
    typedef word_t [4:0] perm_words_t;
    typedef logic [3:0] round_idx_t;
    typedef logic [1:0] cfg_idx_t;

    localparam word_t ASCON_IV = 64'h80400c0600000000;

    localparam round_idx_t ROUND_FIRST = 4'd0;
    localparam round_idx_t ROUND_SQZ_FIRST = 4'd6;
    localparam round_idx_t ROUND_LAST = 4'd11;

    localparam cfg_idx_t REG_KEY_HIGH = 2'd0;
    localparam cfg_idx_t REG_KEY_LOW = 2'd1;
    localparam cfg_idx_t REG_NONCE_HIGH = 2'd2;
    localparam cfg_idx_t REG_NONCE_LOW = 2'd3;

    function automatic logic [7:0] round_const(input round_idx_t r);
        logic [7:0] c;
        case (r)
            4'd0:    c = 8'hf0;
            4'd1:    c = 8'he1;
            4'd2:    c = 8'hd2;
            4'd3:    c = 8'hc3;
            4'd4:    c = 8'hb4;
            4'd5:    c = 8'ha5;
            4'd6:    c = 8'h96;
            4'd7:    c = 8'h87;
            4'd8:    c = 8'h78;
            4'd9:    c = 8'h69;
            4'd10:   c = 8'h5a;
            4'd11:   c = 8'h4b;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic word_t ror64(input word_t v, input int unsigned n);
        return (v >> n) | (v << (64 - n));
    endfunction

endpackage

FILE: rtl/ascon_keystream_xor.sv
// top level: byte-serial ascon keystream xor with a round-per-cycle sequencer
// depends on ascon_ks_pkg, ascon_ks_round and ascon_keystream_xor_assert.svh
//
// channel | signals                          | direction | transfer when
// input   | in_valid in_ready data_byte restart | in     | in_valid & in_ready
// output  | out_valid out_ready out_byte     | out       | out_valid & out_ready
// config  | cfg_we cfg_index cfg_data        | in        | cfg_we
//
// one permutation round per cycle in a single shared round unit
// plain byte: output step only; byte that opens a new block: 6 squeeze rounds first
// restart byte: 12 init rounds, then 6 squeeze rounds
// in_ready is high only while the sequencer is idle; the output register lets
// the next transfer in while a result waits for out_ready
// reset clears state words, stream block and keys to zero
`include "ascon_keystream_xor_assert.svh"

module ascon_keystream_xor
    import ascon_ks_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        restart,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    input  logic        cfg_we,
    input  cfg_idx_t    cfg_index,
    input  word_t       cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_INIT = 2'd1;
    localparam logic [1:0] ST_SQZ  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]  state_reg, state_next;
    round_idx_t  rnd_reg, rnd_next;
    logic [3:0]  pos_reg, pos_next;
    perm_words_t words_reg, words_next;
    word_t       block_reg, block_next;
    logic [7:0]  data_reg, data_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    word_t       key_high_reg, key_high_next;
    word_t       key_low_reg, key_low_next;
    word_t       nonce_high_reg, nonce_high_next;
    word_t       nonce_low_reg, nonce_low_next;

    perm_words_t round_words;
    word_t       block_shifted;

    ascon_ks_round u_round
    (
        .words  (words_reg),
        .rnd    (rnd_reg),
        .result (round_words)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_byte = out_byte_reg;
    assign block_shifted = block_reg << {pos_reg[2:0], 3'b000};

    always_comb
    begin
        state_next = state_reg;
        rnd_next = rnd_reg;
        pos_next = pos_reg;
        words_next = words_reg;
        block_next = block_reg;
        data_next = data_reg;
        out_valid_next = out_valid_reg;
        out_byte_next = out_byte_reg;
        key_high_next = key_high_reg;
        key_low_next = key_low_reg;
        nonce_high_next = nonce_high_reg;
        nonce_low_next = nonce_low_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY_HIGH:   key_high_next = cfg_data;
                REG_KEY_LOW:    key_low_next = cfg_data;
                REG_NONCE_HIGH: nonce_high_next = cfg_data;
                REG_NONCE_LOW:  nonce_low_next = cfg_data;
                default:        key_high_next = key_high_reg;
            endcase
        end

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    data_next = data_byte;
                    if (restart)
                    begin
                        words_next = {nonce_low_reg, nonce_high_reg,
                                      key_low_reg, key_high_reg, ASCON_IV};
                        rnd_next = ROUND_FIRST;
                        state_next = ST_INIT;
                    end
                    else if (pos_reg[3])
                    begin
                        block_next = words_reg[0];
                        rnd_next = ROUND_SQZ_FIRST;
                        pos_next = 4'd0;
                        state_next = ST_SQZ;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_INIT:
            begin
                words_next = round_words;
                if (rnd_reg == ROUND_LAST)
                begin
                    words_next[3] = round_words[3] ^ key_high_reg;
                    words_next[4] = round_words[4] ^ key_low_reg;
                    block_next = round_words[0];
                    rnd_next = ROUND_SQZ_FIRST;
                    pos_next = 4'd0;
                    state_next = ST_SQZ;
                end
                else
                begin
                    rnd_next = rnd_reg + 4'd1;
                end
            end
            ST_SQZ:
            begin
                words_next = round_words;
                if (rnd_reg == ROUND_LAST)
                    state_next = ST_OUT;
                else
                    rnd_next = rnd_reg + 4'd1;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_byte_next = data_reg ^ block_shifted[63:56];
                    out_valid_next = 1'b1;
                    pos_next = pos_reg + 4'd1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rnd_reg <= ROUND_FIRST;
            pos_reg <= 4'd0;
            words_reg <= '0;
            block_reg <= '0;
            out_valid_reg <= 1'b0;
            key_high_reg <= '0;
            key_low_reg <= '0;
            nonce_high_reg <= '0;
            nonce_low_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg <= rnd_next;
            pos_reg <= pos_next;
            words_reg <= words_next;
            block_reg <= block_next;
            out_valid_reg <= out_valid_next;
            key_high_reg <= key_high_next;
            key_low_reg <= key_low_next;
            nonce_high_reg <= nonce_high_next;
            nonce_low_reg <= nonce_low_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        out_byte_reg <= out_byte_next;
    end

    // result only appears at the end of a sequencer pass
    `AKX_ASSERT_NOW(a_out_from_seq, clk, rst_n, $rose(out_valid_reg),
        $past(state_reg) == ST_OUT, "result valid without sequencer pass")
    // byte position never runs past one block
    `AKX_ASSERT_NOW(a_pos_range, clk, rst_n, 1'b1, pos_reg <= 4'd8,
        "byte position out of range")
    // an accepted transfer always starts work
    `AKX_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && in_ready,
        state_reg != ST_IDLE, "transfer accepted but sequencer idle")
    // squeeze rounds stay in the last half of the schedule
    `AKX_ASSERT_NOW(a_sqz_rounds, clk, rst_n, state_reg == ST_SQZ,
        (rnd_reg >= ROUND_SQZ_FIRST) && (rnd_reg <= ROUND_LAST),
        "squeeze round index out of range")

endmodule

FILE: rtl/ascon_ks_round.sv
// one ascon permutation round: constant addition, s-box layer, linear layer
// depends on ascon_ks_pkg
module ascon_ks_round
    import ascon_ks_pkg::*;
(
    input  perm_words_t words,
    input  round_idx_t  rnd,
    output perm_words_t result
);

    word_t t0, t1, t2, t3, t4;
    word_t b0, b1, b2, b3, b4;
    word_t c0, c1, c2, c3, c4;

    always_comb
    begin
        t0 = words[0] ^ words[4];
        t1 = words[1];
        t2 = words[2] ^ {56'd0, round_const(rnd)} ^ words[1];
        t3 = words[3];
        t4 = words[4] ^ words[3];

        b0 = t0 ^ (~t1 & t2);
        b1 = t1 ^ (~t2 & t3);
        b2 = t2 ^ (~t3 & t4);
        b3 = t3 ^ (~t4 & t0);
        b4 = t4 ^ (~t0 & t1);

        c0 = b0 ^ b4;
        c1 = b1 ^ b0;
        c2 = ~b2;
        c3 = b3 ^ b2;
        c4 = b4;

        result[0] = c0 ^ ror64(c0, 19) ^ ror64(c0, 28);
        result[1] = c1 ^ ror64(c1, 61) ^ ror64(c1, 39);
        result[2] = c2 ^ ror64(c2, 1) ^ ror64(c2, 6);
        result[3] = c3 ^ ror64(c3, 10) ^ ror64(c3, 17);
        result[4] = c4 ^ ror64(c4, 7) ^ ror64(c4, 41);
    end

endmodule

FILE: test/ascon_keystream_xor_checker.sv
// checker for ascon_keystream_xor: follows config writes and input transfers, predicts
// every output byte from its own ascon sponge copy and compares output transfers in order
// depends on ascon_ks_pkg
module ascon_keystream_xor_checker
    import ascon_ks_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       restart,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] out_byte,
    input  logic       cfg_we,
    input  cfg_idx_t   cfg_index,
    input  word_t      cfg_data,
    output int         mismatches,
    output int         outstanding
);

    word_t       key_hi;
    word_t       key_lo;
    word_t       nonce_hi;
    word_t       nonce_lo;
    perm_words_t sponge;
    word_t       squeezed;
    int unsigned used_bytes;
    logic [7:0]  expected_bytes [$];

    function automatic word_t rot_right(input word_t v, input int unsigned n);
        logic [127:0] twice;
        twice = {v, v} >> n;
        return twice[63:0];
    endfunction

    function automatic perm_words_t sponge_round(input perm_words_t s, input round_idx_t r);
        logic [3:0]  hi_nib;
        word_t       x0, x1, x2, x3, x4;
        word_t       t0, t1, t2, t3, t4;
        perm_words_t next_s;
        hi_nib = 4'hf - r;
        x0 = s[0];
        x1 = s[1];
        x2 = s[2] ^ {56'd0, hi_nib, r};
        x3 = s[3];
        x4 = s[4];
        x0 = x0 ^ x4;
        x4 = x4 ^ x3;
        x2 = x2 ^ x1;
        t0 = x0 ^ (~x1 & x2);
        t1 = x1 ^ (~x2 & x3);
        t2 = x2 ^ (~x3 & x4);
        t3 = x3 ^ (~x4 & x0);
        t4 = x4 ^ (~x0 & x1);
        t1 = t1 ^ t0;
        t0 = t0 ^ t4;
        t3 = t3 ^ t2;
        t2 = ~t2;
        next_s[0] = t0 ^ rot_right(t0, 19) ^ rot_right(t0, 28);
        next_s[1] = t1 ^ rot_right(t1, 61) ^ rot_right(t1, 39);
        next_s[2] = t2 ^ rot_right(t2, 1) ^ rot_right(t2, 6);
        next_s[3] = t3 ^ rot_right(t3, 10) ^ rot_right(t3, 17);
        next_s[4] = t4 ^ rot_right(t4, 7) ^ rot_right(t4, 41);
        return next_s;
    endfunction

    task automatic permute_from(input round_idx_t first);
        for (int r = first; r <= ROUND_LAST; r++)
        begin
            sponge = sponge_round(sponge, round_idx_t'(r));
        end
    endtask

    task automatic squeeze_next();
        squeezed = sponge[0];
        permute_from(ROUND_SQZ_FIRST);
        used_bytes = 0;
    endtask

    task automatic load_key_nonce();
        sponge[0] = ASCON_IV;
        sponge[1] = key_hi;
        sponge[2] = key_lo;
        sponge[3] = nonce_hi;
        sponge[4] = nonce_lo;
        permute_from(ROUND_FIRST);
        sponge[3] = sponge[3] ^ key_hi;
        sponge[4] = sponge[4] ^ key_lo;
        squeeze_next();
    endtask

    always @(posedge clk)
    begin : monitor
        logic [7:0] want;
        if (!rst_n)
        begin
            key_hi = '0;
            key_lo = '0;
            nonce_hi = '0;
            nonce_lo = '0;
            sponge = '0;
            squeezed = '0;
            used_bytes = 0;
            expected_bytes.delete();
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected out_byte transfer, expected none, actual %02h",
                             $time, out_byte);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_byte !== want)
                    begin
                        mismatches++;
                        $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                                 $time, want, out_byte);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (restart)
                    load_key_nonce();
                if (used_bytes >= 8)
                    squeeze_next();
                want = data_byte ^ squeezed[63 - 8 * used_bytes -: 8];
                used_bytes++;
                expected_bytes.push_back(want);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_KEY_HIGH:   key_hi = cfg_data;
                    REG_KEY_LOW:    key_lo = cfg_data;
                    REG_NONCE_HIGH: nonce_hi = cfg_data;
                    REG_NONCE_LOW:  nonce_lo = cfg_data;
                    default:        ;
                endcase
            end
            outstanding = expected_bytes.size();
        end
    end

endmodule

FILE: test/ascon_keystream_xor_tb.sv
// testbench top for ascon_keystream_xor: clock, reset, config writes, bursty byte stimulus
// and a stalling receiver; depends on ascon_ks_pkg, the block and ascon_keystream_xor_checker
module ascon_keystream_xor_tb;
    import ascon_ks_pkg::*;

    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_ITEMS = 1000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] data_byte = 8'h00;
    logic       restart = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       cfg_we = 1'b0;
    cfg_idx_t   cfg_index = REG_KEY_HIGH;
    word_t      cfg_data = '0;

    int   mismatches;
    int   outstanding;
    int   hold_requests = 0;
    int   hold_cycles = 0;

    always #10 clk = ~clk;

    ascon_keystream_xor uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .restart   (restart),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ascon_keystream_xor_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // receiver stall pattern, with an occasional long hold-off on request
    always
    begin : receiver
        int mode;
        int left;
        int tick;
        int served;
        @(negedge clk);
        if (hold_requests != served)
        begin
            out_ready <= 1'b0;
            repeat (hold_cycles) @(negedge clk);
            served = hold_requests;
        end
        else
        begin
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 200);
            end
            left--;
            tick++;
            case (mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= 1'($urandom_range(0, 1));
                2:       out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= (tick % 5 != 4);
            endcase
        end
    end

    task automatic send_byte(input logic [7:0] d, input logic rs);
        @(negedge clk);
        in_valid <= 1'b1;
        data_byte <= d;
        restart <= rs;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic pause(input int n);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic settle_idle(input int extra);
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (extra) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input word_t v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic word_t pick_word();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return '0;
        else if (sel == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    initial
    begin : stimulus
        int phase;
        int sent;
        int n;
        int k;
        int burst;
        logic open_restart;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // no restart since reset: first block passes bytes through, then zero-state squeezes
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'haa, 1'b0);
        send_byte(8'h7f, 1'b0);
        send_byte(8'hfe, 1'b0);
        repeat (4) send_byte(8'h3c, 1'b0);

        settle_idle(SETTLE_CYCLES);
        write_reg(REG_KEY_HIGH, '1);
        write_reg(REG_KEY_LOW, '1);
        write_reg(REG_NONCE_HIGH, '0);
        write_reg(REG_NONCE_LOW, '1);
        send_byte(8'h00, 1'b1);
        for (k = 0; k < 8; k++)
            send_byte(8'(k * 37 + 1), 1'b0);
        send_byte(8'hff, 1'b1);

        // key change mid-stream only counts from the next restart
        settle_idle(SETTLE_CYCLES);
        write_reg(REG_KEY_HIGH, 64'h0123456789abcdef);
        send_byte(8'h5a, 1'b0);
        send_byte(8'ha5, 1'b0);
        send_byte(8'h00, 1'b1);

        phase = 0;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            settle_idle(SETTLE_CYCLES);
            for (k = 0; k < 4; k++)
            begin
                if ($urandom_range(0, 3) != 0)
                    write_reg(cfg_idx_t'(k), pick_word());
            end
            if (phase == 2)
            begin
                hold_cycles = 400;
                hold_requests++;
                for (k = 0; k < 40; k++)
                    send_byte(8'($urandom_range(0, 255)), k == 0);
                sent += 40;
            end
            else
            begin
                n = $urandom_range(20, 120);
                open_restart = ($urandom_range(0, 7) != 0);
                k = 0;
                while (k < n)
                begin
                    burst = $urandom_range(1, 40);
                    while (burst > 0 && k < n)
                    begin
                        send_byte(8'($urandom_range(0, 255)),
                                  (k == 0 && open_restart) || ($urandom_range(0, 29) == 0));
                        burst--;
                        k++;
                    end
                    if ($urandom_range(0, 2) != 0)
                        pause($urandom_range(1, 15));
                end
                sent += n;
            end
            phase++;
        end

        settle_idle(40);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
